### hw/rtl/rfae_pkg.sv
// Package for the register file ALU executor.
// Holds sizes, opcode/status/state enums and the channel payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rfae_pkg;

	localparam int NUM_REGS   = 6;
	localparam int DATA_W     = 32;
	localparam int REG_IDX_W  = 3;
	localparam int REG_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int DIV_CNT_W  = $clog2(DATA_W);

	localparam logic [REG_IDX_W-1:0] NUM_REGS_IDX = REG_IDX_W'(NUM_REGS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST     = DIV_CNT_W'(DATA_W - 1);

	typedef enum logic [2:0] {
		OP_MOV = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_MUL = 3'd3,
		OP_DIV = 3'd4,
		OP_INC = 3'd5,
		OP_DEC = 3'd6,
		OP_END = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_REG  = 2'd1,
		ST_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [REG_IDX_W-1:0]   dest_index;
		logic [REG_IDX_W-1:0]   source_index;
	} cmd_t;

	typedef struct packed {
		status_t                status;
		logic signed [DATA_W-1:0] dest_value;
	} rsp_t;

endpackage

`default_nettype wire

### hw/rtl/rfae_if.sv
// Valid/ready channel interfaces for the executor.
// Depends on rfae_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface rfae_cmd_if;
	logic           valid;
	logic           ready;
	rfae_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rfae_rsp_if;
	logic           valid;
	logic           ready;
	rfae_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/rfae_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rfae_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/rfae_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rfae_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rfae_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [rfae_pkg::DATA_W-1:0] dividend,
	input  wire logic [rfae_pkg::DATA_W-1:0] divisor,
	output logic                             done,
	output logic      [rfae_pkg::DATA_W-1:0] quotient
);
	import rfae_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic [DATA_W-1:0]    mb_q;
	logic [DATA_W-1:0]    rem_q;
	logic [DATA_W-1:0]    quo_q;
	logic [DATA_W:0]      rem_sh;
	logic [DATA_W+1:0]    diff;

	assign rem_sh   = {rem_q, quo_q[DATA_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, mb_q};
	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			mb_q  <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			quo_q <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= diff[DATA_W+1] ? rem_sh[DATA_W-1:0] : diff[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W+1]};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/register_file_alu_executor.sv
// Register file ALU executor: runs decoded two-register instructions.
// Depends on rfae_pkg, rfae_if, rfae_ram and rfae_div.
//
// Usage:
//   cmd carries one decoded instruction per transaction (opcode, dest_index,
//   source_index); rsp returns one transaction per instruction with a status
//   and the destination register's new value.
//   The register file sits in two mirrored RAMs with a registered read,
//   so both operands are read in the cycle after acceptance. Per-entry
//   valid bits make every register read as zero after reset.
//   After acceptance the operands are read in S_READ and the result is
//   registered; in S_DONE it is written back and loaded into the output
//   register. A divide starts the iterative divider from S_READ and waits in
//   S_DIV until it is done; the divider produces one quotient bit per cycle.
//   One instruction is in flight at a time; cmd is ready only in S_IDLE. A
//   finished result waits in the output register while the next
//   instruction is accepted and executed; that instruction then holds in
//   its final state until rsp is taken. Divide by zero skips S_DIV; bad
//   indices skip the read and go from acceptance straight to S_DONE.
//   Reset (arst_n low) clears all registers to zero and empties the output.
`timescale 1ns / 1ps
`default_nettype none

module register_file_alu_executor (
	input wire logic   clk,
	input wire logic   arst_n,
	rfae_cmd_if.sink   cmd,
	rfae_rsp_if.source rsp
);
	import rfae_pkg::*;

	state_t              state_q, state_d;
	opcode_t             op_q;
	logic [REG_AW-1:0]   d_q;
	logic [REG_AW-1:0]   s_q;
	logic [DATA_W-1:0]   r_q;
	status_t             st_q;
	logic [NUM_REGS-1:0] vld_q;
	logic                out_vld_q;
	rsp_t                out_q;

	logic                cmd_bad;
	logic                accept;
	logic                done_go;
	logic                wr_en;
	logic                div_start;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;
	logic [DATA_W-1:0]   rd_a;
	logic [DATA_W-1:0]   rd_b;
	logic [DATA_W-1:0]   a_opnd;
	logic [DATA_W-1:0]   b_opnd;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0]   alu_res;
	status_t             alu_st;

	assign cmd_bad = (cmd.data.dest_index >= NUM_REGS_IDX) ||
	                 (cmd.data.source_index >= NUM_REGS_IDX);
	assign accept  = cmd.valid && cmd.ready;

	rfae_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
		.clk   (clk),
		.we    (wr_en),
		.waddr (d_q),
		.wdata (r_q),
		.raddr (cmd.data.dest_index[REG_AW-1:0]),
		.rdata (rd_a)
	);

	rfae_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
		.clk   (clk),
		.we    (wr_en),
		.waddr (d_q),
		.wdata (r_q),
		.raddr (cmd.data.source_index[REG_AW-1:0]),
		.rdata (rd_b)
	);

	rfae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (a_opnd),
		.divisor  (b_opnd),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign a_opnd = vld_q[d_q] ? rd_a : '0;
	assign b_opnd = vld_q[s_q] ? rd_b : '0;
	assign prod   = a_opnd * b_opnd;

	always_comb begin
		alu_res = a_opnd;
		alu_st  = ST_OK;
		case (op_q)
			OP_MOV: alu_res = b_opnd;
			OP_ADD: alu_res = a_opnd + b_opnd;
			OP_SUB: alu_res = a_opnd - b_opnd;
			OP_MUL: alu_res = prod[DATA_W-1:0];
			OP_DIV: begin
				if (b_opnd == '0) begin
					alu_st = ST_DIV_ZERO;
				end
			end
			OP_INC: alu_res = a_opnd + DATA_W'(1);
			OP_DEC: alu_res = a_opnd - DATA_W'(1);
			default: alu_res = a_opnd;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = cmd_bad ? S_DONE : S_READ;
				end
			end
			S_READ: begin
				if (op_q == OP_DIV && b_opnd != '0) begin
					state_d = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (done_go) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		cmd.ready = 1'b0;
		div_start = 1'b0;
		done_go   = 1'b0;
		case (state_q)
			S_IDLE: cmd.ready = 1'b1;
			S_READ: div_start = (op_q == OP_DIV) && (b_opnd != '0);
			S_DONE: done_go   = !out_vld_q || rsp.ready;
			default: ;
		endcase
	end

	assign wr_en     = done_go && (st_q != ST_BAD_REG);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[d_q] <= 1'b1;
			end
			if (done_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= cmd.data.opcode;
			d_q  <= cmd.data.dest_index[REG_AW-1:0];
			s_q  <= cmd.data.source_index[REG_AW-1:0];
			r_q  <= '0;
			st_q <= cmd_bad ? ST_BAD_REG : ST_OK;
		end else if (state_q == S_READ) begin
			r_q  <= alu_res;
			st_q <= alu_st;
		end else if (state_q == S_DIV && div_done) begin
			r_q <= div_quo;
		end
		if (done_go) begin
			out_q.status     <= st_q;
			out_q.dest_value <= r_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_BAD_REG |-> rsp.data.dest_value == '0)
		else $error("bad-register result with nonzero value");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> op_q == OP_DIV)
		else $error("divider wait without a divide instruction");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> state_q == S_IDLE && rsp.valid)
		else $error("write-back without a posted result");

endmodule

`default_nettype wire
